/* rtl/ghk_pkg.sv */
// Shared types and constants for the grid height Kalman update block.
// No dependencies; every other file in rtl/ but ghk_ram imports this package.
package ghk_pkg;

    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 64;

    localparam logic [31:0] RST_NOISE   = 32'd655;
    localparam logic [15:0] RST_SCALE   = 16'd2560;
    localparam logic [31:0] RST_INITVAR = 32'd6553600;

    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE   = 2'd0,
        CFG_SCALE   = 2'd1,
        CFG_INITVAR = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    // Shared multiplier operands are signed 34 bits so that a signed
    // coordinate and any unsigned 33-bit quantity both fit.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Grid index is ceil(product / 2^24) of a Q16.16 by Q8.8 product.
    localparam int IDX_SHIFT = 24;
    localparam int IDX_W     = 25;
    localparam logic signed [PROD_W-1:0] CEIL_BIAS =
        PROD_W'((64'd1 << IDX_SHIFT) - 64'd1);

    localparam int GAIN_W = 33;
    localparam int DEN_W  = 65;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

endpackage

/* rtl/grid_height_kalman_update_unit.sv */
// Top level of the grid height Kalman update block: sequencer, config, map store.
// Depends on ghk_pkg, ghk_ram, ghk_mul and ghk_div.
//
// Usage. Points arrive on the s_ channel (valid/ready), one word per point
// with x, y and z in signed Q16.16. Each point produces exactly one result
// word on the m_ channel: the touched cell, its new height and variance, or
// in_map low with all other fields zero when the point falls off the grid.
// Configuration writes use the cfg_ channel (index, data); cfg_ready is
// always high and writes are meant to happen while no point is in flight.
// Writing initial_variance changes nothing after reset: the map is only
// loaded with the reset value by the clearing pass.
//
// Timing. A point is worked on by one shared 34x34 multiplier under a small
// sequencer, plus a one-bit-per-cycle divider for the gain. A dropped point
// leaves out the map read, the gain and the update and goes straight to the
// result word. s_ready is low from acceptance until the result is
// moved into the output register; the output register holds one finished
// word, so the next point can be accepted while the receiver stalls, and the
// sequencer only waits if a second result finishes before the first is taken.
//
// Reset. After aresetn the block sweeps the map store one cell per cycle,
// over all GRID_COLS*GRID_ROWS cells, writing height 0 and the reset variance; it
// accepts no point during that pass.
module grid_height_kalman_update_unit #(
    parameter int GRID_COLS = ghk_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = ghk_pkg::DEF_GRID_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_point_x,
    input  logic signed [31:0]              s_point_y,
    input  logic signed [31:0]              s_point_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_in_map,
    output logic [5:0]                      m_cell_col,
    output logic [5:0]                      m_cell_row,
    output logic signed [31:0]              m_new_height,
    output logic [31:0]                     m_new_variance,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ghk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import ghk_pkg::*;

    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_COL, ST_ROW, ST_SX, ST_SY, ST_SZ, ST_SUM,
        ST_R1, ST_R2, ST_R3, ST_DEN, ST_DIVGO, ST_DIV, ST_HGT, ST_VAR,
        ST_WR, ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [31:0]              noise_reg, noise_next;
    logic [15:0]              scale_reg, scale_next;
    logic signed [31:0]       x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [IDX_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic [63:0]              s_reg, s_next, r_reg, r_next;
    logic signed [31:0]       h_reg, h_next;
    logic [31:0]              v_reg, v_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [31:0]       nh_reg, nh_next;
    logic [31:0]              nv_reg, nv_next;
    logic                     in_map_reg, in_map_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_in_map_reg, m_in_map_next;
    logic [5:0]               m_col_reg, m_col_next, m_row_reg, m_row_next;
    logic signed [31:0]       m_h_reg, m_h_next;
    logic [31:0]              m_v_reg, m_v_next;

    mul_op_t                  mul_a, mul_b;
    mul_prod_t                prod;
    mul_prod_t                ceil_sum;
    logic [31:0]              ax, ay, az;
    logic signed [32:0]       d;
    logic [32:0]              ad;
    logic signed [34:0]       nh_wide;
    logic [GAIN_W-1:0]        one_minus_gain;
    logic                     in_range;
    logic [AW-1:0]            cell_addr;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr;
    logic [63:0]              ram_wdata, ram_rdata;
    logic                     div_start, div_done;
    logic [GAIN_W-1:0]        div_quot;

    // Magnitudes; the two's complement of the most negative value is its
    // magnitude when read as unsigned.
    assign ax = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
    assign ay = y_reg[31] ? (~y_reg + 32'd1) : y_reg;
    assign az = z_reg[31] ? (~z_reg + 32'd1) : z_reg;
    assign d  = {z_reg[31], z_reg} - {h_reg[31], h_reg};
    assign ad = d[32] ? 33'(~d + 33'sd1) : 33'(d);
    assign one_minus_gain = 33'h1_0000_0000 - gain_reg;
    assign ceil_sum = prod + CEIL_BIAS;

    assign in_range = !col_reg[IDX_W-1] && !row_reg[IDX_W-1]
                   && ($unsigned(col_reg) < IDX_W'(GRID_COLS))
                   && ($unsigned(row_reg) < IDX_W'(GRID_ROWS));
    assign cell_addr = AW'(AW'(row_reg[ROW_W-1:0]) * AW'(GRID_COLS))
                     + AW'(col_reg[COL_W-1:0]);

    // Operand selection for the shared multiplier; its product is registered.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_COL: begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'({1'b0, scale_reg});
            end
            ST_ROW: begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'({1'b0, scale_reg});
            end
            ST_SX: begin
                mul_a = MUL_W'({1'b0, ax});
                mul_b = MUL_W'({1'b0, ax});
            end
            ST_SY: begin
                mul_a = MUL_W'({1'b0, ay});
                mul_b = MUL_W'({1'b0, ay});
            end
            ST_SZ: begin
                mul_a = MUL_W'({1'b0, az});
                mul_b = MUL_W'({1'b0, az});
            end
            ST_R1: begin
                mul_a = MUL_W'({1'b0, noise_reg});
                mul_b = MUL_W'({1'b0, s_reg[31:0]});
            end
            ST_R2: begin
                mul_a = MUL_W'({1'b0, noise_reg});
                mul_b = MUL_W'({1'b0, s_reg[63:32]});
            end
            ST_HGT: begin
                mul_a = MUL_W'({1'b0, gain_reg});
                mul_b = MUL_W'({1'b0, ad});
            end
            ST_VAR: begin
                mul_a = MUL_W'({1'b0, one_minus_gain});
                mul_b = MUL_W'({1'b0, v_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // New height: step magnitude with the sign of d, then saturation.
    always_comb begin
        if (d[32]) begin
            nh_wide = 35'(h_reg) - $signed({2'b00, prod[64:32]});
        end else begin
            nh_wide = 35'(h_reg) + $signed({2'b00, prod[64:32]});
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        noise_next    = noise_reg;
        scale_next    = scale_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        s_next        = s_reg;
        r_next        = r_reg;
        h_next        = h_reg;
        v_next        = v_reg;
        den_next      = den_reg;
        gain_next     = gain_reg;
        nh_next       = nh_reg;
        nv_next       = nv_reg;
        in_map_next   = in_map_reg;
        m_valid_next  = m_valid_reg;
        m_in_map_next = m_in_map_reg;
        m_col_next    = m_col_reg;
        m_row_next    = m_row_reg;
        m_h_next      = m_h_reg;
        m_v_next      = m_v_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = cell_addr;
        ram_wdata     = {nh_reg, nv_reg};
        div_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Writes to initial_variance have no lasting effect, so they are dropped.
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NOISE: noise_next = cfg_data;
                CFG_SCALE: scale_next = cfg_data[15:0];
                default:   noise_next = noise_reg;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = {32'd0, RST_INITVAR};
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_point_x;
                    y_next     = s_point_y;
                    z_next     = s_point_z;
                    state_next = ST_COL;
                end
            end
            ST_COL: state_next = ST_ROW;
            ST_ROW: begin
                col_next   = ceil_sum[IDX_SHIFT +: IDX_W];
                state_next = ST_SX;
            end
            ST_SX: begin
                row_next   = ceil_sum[IDX_SHIFT +: IDX_W];
                state_next = ST_SY;
            end
            ST_SY: begin
                if (in_range) begin
                    s_next     = prod[63:0];
                    ram_re     = 1'b1;
                    state_next = ST_SZ;
                end else begin
                    in_map_next = 1'b0;
                    nh_next     = '0;
                    nv_next     = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_SZ: begin
                s_next     = s_reg + prod[63:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                s_next     = s_reg + prod[63:0];
                h_next     = ram_rdata[63:32];
                v_next     = ram_rdata[31:0];
                state_next = ST_R1;
            end
            ST_R1: state_next = ST_R2;
            ST_R2: begin
                r_next     = {32'd0, prod[63:32]};
                state_next = ST_R3;
            end
            ST_R3: begin
                r_next     = r_reg + prod[63:0];
                state_next = ST_DEN;
            end
            ST_DEN: begin
                den_next   = {1'b0, r_reg} + DEN_W'(v_reg);
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                if (den_reg == '0) begin
                    gain_next  = '0;
                    state_next = ST_HGT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    gain_next  = div_quot;
                    state_next = ST_HGT;
                end
            end
            ST_HGT: state_next = ST_VAR;
            ST_VAR: begin
                if (nh_wide[34:31] != {4{nh_wide[34]}}) begin
                    nh_next = nh_wide[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    nh_next = nh_wide[31:0];
                end
                state_next = ST_WR;
            end
            ST_WR: begin
                nv_next     = prod[63:32];
                in_map_next = 1'b1;
                ram_we      = 1'b1;
                ram_wdata   = {nh_reg, prod[63:32]};
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_in_map_next = in_map_reg;
                    m_col_next    = in_map_reg ? col_reg[5:0] : 6'd0;
                    m_row_next    = in_map_reg ? row_reg[5:0] : 6'd0;
                    m_h_next      = nh_reg;
                    m_v_next      = nv_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            noise_reg   <= RST_NOISE;
            scale_reg   <= RST_SCALE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            noise_reg   <= noise_next;
            scale_reg   <= scale_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        s_reg        <= s_next;
        r_reg        <= r_next;
        h_reg        <= h_next;
        v_reg        <= v_next;
        den_reg      <= den_next;
        gain_reg     <= gain_next;
        nh_reg       <= nh_next;
        nv_reg       <= nv_next;
        in_map_reg   <= in_map_next;
        m_in_map_reg <= m_in_map_next;
        m_col_reg    <= m_col_next;
        m_row_reg    <= m_row_next;
        m_h_reg      <= m_h_next;
        m_v_reg      <= m_v_next;
    end

    ghk_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    ghk_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ghk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .v       (v_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_in_map       = m_in_map_reg;
    assign m_cell_col     = m_col_reg;
    assign m_cell_row     = m_row_reg;
    assign m_new_height   = m_h_reg;
    assign m_new_variance = m_v_reg;

`ifndef ASSERT_OFF
    // Only one point is in flight at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("point accepted while another is in flight");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result arrived outside the wait state");

    // A map write from the update path is always reported as an in-map result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |=> (in_map_reg && state_reg == ST_DONE))
        else $error("cell write not followed by an in-map result");

    // A new result word appears only out of the hand-off state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the hand-off state");
`endif
endmodule

/* rtl/ghk_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ghk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/ghk_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on ghk_pkg for operand and product types.
module ghk_mul (
    input  logic              aclk,
    input  ghk_pkg::mul_op_t   a,
    input  ghk_pkg::mul_op_t   b,
    output ghk_pkg::mul_prod_t prod
);
    import ghk_pkg::*;

    mul_prod_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

/* rtl/ghk_div.sv */
// Restoring divider for the Kalman gain: floor(v * 2^32 / den), one bit a cycle.
// Depends on ghk_pkg for widths. Requires den >= v and den != 0.
module ghk_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 v,
    input  logic [ghk_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [ghk_pkg::GAIN_W-1:0]  quot
);
    import ghk_pkg::*;

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [GAIN_W-1:0] feed_reg, feed_next;
    logic [GAIN_W-1:0] q_reg, q_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    always_comb begin
        trial     = {rem_reg, feed_reg[GAIN_W-1]};
        diff      = trial - {1'b0, den};
        fits      = (trial >= {1'b0, den});
        rem_next  = rem_reg;
        feed_next = feed_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            // The top bits of v * 2^32 above the quotient range are below den.
            rem_next  = DEN_W'(v[31:1]);
            feed_next = {v[0], 32'd0};
            q_next    = '0;
            cnt_next  = 6'(GAIN_W);
        end else if (cnt_reg != 6'd0) begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next    = {q_reg[GAIN_W-2:0], fits};
            feed_next = {feed_reg[GAIN_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        feed_reg <= feed_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

/* tb/grid_height_kalman_update_checker.sv */
`timescale 1ns / 1ps
// Checker for grid_height_kalman_update_unit: watches the point, result and config channels.
// Depends on ghk_pkg; keeps its own copy of the map and registers to predict each result word.
module grid_height_kalman_update_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [31:0]            s_point_x,
    input  logic signed [31:0]            s_point_y,
    input  logic signed [31:0]            s_point_z,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_in_map,
    input  logic [5:0]                    m_cell_col,
    input  logic [5:0]                    m_cell_row,
    input  logic signed [31:0]            m_new_height,
    input  logic [31:0]                   m_new_variance,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ghk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            mismatch_count,
    output int                            pending_count
);
    import ghk_pkg::*;

    typedef struct packed {
        logic        in_map;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [31:0] height;
        logic [31:0] variance;
    } cell_update_t;

    logic [31:0] noise_reg;
    logic [15:0] scale_reg;
    logic [31:0] height_map [4096];
    logic [31:0] variance_map [4096];
    cell_update_t expected_updates [$];

    // Exact ceil of coord * scale / 2^24, with room to spare in 64 bits.
    function automatic longint cell_index(logic signed [31:0] coord, logic [15:0] scale);
        longint p;
        p = longint'(coord) * longint'({1'b0, scale});
        if (p >= 0)
            return (p + 64'hFFFFFF) >>> 24;
        return -((-p) >>> 24);
    endfunction

    function automatic cell_update_t predict_word(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
        cell_update_t    u;
        longint          col, row, h, d, nh;
        int              idx;
        logic [63:0]     ax, ay, az, s, r, v, ad;
        logic [64:0]     den;
        logic [127:0]    gain, mag, nv;
        u = '0;
        col = cell_index(x, scale_reg);
        row = cell_index(y, scale_reg);
        if (col < 0 || col > 63 || row < 0 || row > 63)
            return u;
        idx = int'(row * 64 + col);
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        az = (z < 0) ? -longint'(z) : longint'(z);
        s = ax * ax + ay * ay + az * az;
        r = 64'(noise_reg) * s[63:32] + ((64'(noise_reg) * s[31:0]) >> 32);
        v = 64'(variance_map[idx]);
        den = 65'(v) + 65'(r);
        gain = (den == 0) ? 128'd0 : ({32'd0, v, 32'd0} / 128'(den));
        h = longint'(signed'(height_map[idx]));
        d = longint'(z) - h;
        ad = (d < 0) ? -d : d;
        mag = (gain * 128'(ad)) >> 32;
        nh = (d < 0) ? h - longint'(mag) : h + longint'(mag);
        if (nh > 64'sd2147483647) nh = 64'sd2147483647;
        if (nh < -64'sd2147483648) nh = -64'sd2147483648;
        nv = ((128'h1_0000_0000 - gain) * 128'(v)) >> 32;
        height_map[idx] = nh[31:0];
        variance_map[idx] = nv[31:0];
        u.in_map = 1'b1;
        u.col = col[5:0];
        u.row = row[5:0];
        u.height = nh[31:0];
        u.variance = nv[31:0];
        return u;
    endfunction

    always @(posedge aclk) begin
        cell_update_t exp_u, got;
        if (!aresetn) begin
            noise_reg = RST_NOISE;
            scale_reg = RST_SCALE;
            for (int i = 0; i < 4096; i++) begin
                height_map[i] = '0;
                variance_map[i] = RST_INITVAR;
            end
            expected_updates.delete();
            mismatch_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_NOISE: noise_reg = cfg_data;
                    CFG_SCALE: scale_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_updates.push_back(predict_word(s_point_x, s_point_y, s_point_z));
            if (m_valid && m_ready) begin
                got = {m_in_map, m_cell_col, m_cell_row, m_new_height, m_new_variance};
                if (expected_updates.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result word %h", got);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_u = expected_updates.pop_front();
                    if (got !== exp_u) begin
                        if (mismatch_count < 10)
                            $display("mismatch exp %0d/%0d/%0d %h %h got %0d/%0d/%0d %h %h",
                                     exp_u.in_map, exp_u.col, exp_u.row, exp_u.height,
                                     exp_u.variance, got.in_map, got.col, got.row,
                                     got.height, got.variance);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
        pending_count <= expected_updates.size();
    end
endmodule

/* tb/tb_grid_height_kalman_update_unit.sv */
`timescale 1ns / 1ps
// Top of the grid height Kalman update testbench: clock, reset, stimulus and verdict.
// Depends on ghk_pkg, the block and grid_height_kalman_update_checker.
module tb_grid_height_kalman_update_unit;
    import ghk_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_valid, s_ready;
    logic signed [31:0] s_point_x, s_point_y, s_point_z;
    logic              m_valid, m_ready;
    logic              m_in_map;
    logic [5:0]        m_cell_col, m_cell_row;
    logic signed [31:0] m_new_height;
    logic [31:0]       m_new_variance;
    logic              cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]       cfg_data;
    int                mismatch_count, pending_count;

    // Once this is set, neither the point source nor the result sink idles.
    bit                steady_phase;

    grid_height_kalman_update_unit dut (.*);
    grid_height_kalman_update_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The result sink stalls in random bursts, with stretches of steady
    // acceptance between them.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!steady_phase && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Offer one point word, wait until the block takes it, then perhaps idle.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        s_valid <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!steady_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
    endtask

    // Registers are only written once every expected word has come back, the
    // words of dropped points included, and after a further idle wait.
    task automatic write_register(cfg_idx_t idx, logic [31:0] data);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random coordinate: mostly on the grid for the current scale, sometimes
    // any 32-bit value so that every bit and the off-grid cases are covered.
    function automatic logic [31:0] grid_coord(int span);
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        return 32'($urandom_range(0, span)) - 32'($urandom_range(0, 40000));
    endfunction

    function automatic logic [31:0] height_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($urandom_range(0, 2000000)) - 32'd1000000;
        endcase
    endfunction

    task automatic random_points(int count, int span, bit hot_cells);
        logic [31:0] x, y;
        for (int i = 0; i < count; i++) begin
            // A narrow window keeps hitting a few cells, so updates pile up.
            x = hot_cells ? 32'($urandom_range(0, 3) << 16) : grid_coord(span);
            y = hot_cells ? 32'($urandom_range(0, 3) << 16) : grid_coord(span);
            send_point(x, y, height_sample());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_point_x = '0;
        s_point_y = '0;
        s_point_z = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NOISE;
        cfg_data = '0;
        steady_phase = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words: extremes of each coordinate, two grid corners and points
        // just inside the far column edge and just outside the far row edge.
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h0);
        send_point(32'h0, 32'h7FFF_FFFF, 32'h1);
        send_point(32'h0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
        send_point(32'h0006_4000, 32'h0006_4000, 32'h0002_0000);
        send_point(32'h0006_4CCC, 32'h0, 32'h0);
        send_point(32'h0, 32'h0006_4CCD, 32'h0);
        send_point(32'h0000_0001, 32'h0000_0001, 32'h0003_0000);

        // Zero noise makes the gain one; zero scale sends everything to (0,0).
        write_register(CFG_NOISE, 32'h0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0005_0000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0006_0000);
        write_register(CFG_SCALE, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0004_0000);
        // Cell (0,0) now has variance 0, so the denominator is zero.
        send_point(32'h0, 32'h0, 32'h0007_0000);
        write_register(CFG_INITVAR, 32'hFFFF_FFFF);
        write_register(CFG_NONE, 32'h1234_5678);
        write_register(CFG_NOISE, 32'hFFFF_FFFF);
        write_register(CFG_SCALE, 32'h0000_FFFF);
        send_point(32'h0000_0010, 32'h0000_0020, 32'h8000_0000);
        send_point(32'h0000_3F00, 32'h0000_3F00, 32'h7FFF_FFFF);

        // Random phases across several register settings.
        write_register(CFG_NOISE, 32'd655);
        write_register(CFG_SCALE, 32'd2560);
        random_points(200, 420000, 1'b0);
        random_points(60, 0, 1'b1);
        write_register(CFG_NOISE, $urandom());
        write_register(CFG_SCALE, 32'h0000_0100);
        write_register(CFG_INITVAR, 32'd0);
        random_points(150, 64 << 16, 1'b0);
        write_register(CFG_NOISE, 32'd1);
        write_register(CFG_SCALE, 32'($urandom_range(1, 65535)));
        random_points(100, 200000, 1'b0);
        write_register(CFG_SCALE, 32'h0000_0800);
        steady_phase = 1'b1;
        random_points(120, 8 << 16, 1'b0);
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
